// ===== hw/rtl/tlbc_pkg.sv =====
// Shared types and constants for the TLB with clock replacement.
`timescale 1ns / 1ps

package tlbc_pkg;

  // Sizes of the buffer and of its fields.
  localparam int ENTRIES    = 16;
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int FILL_W     = $clog2(ENTRIES + 1);
  localparam int CNT_W      = 32;

  // Operation codes of an input item.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Input item.
  typedef struct packed {
    logic                  op;
    logic [PAGE_BITS-1:0]  vpn;
    logic [FRAME_BITS-1:0] pfn;
    logic                  readonly;
  } tlbc_in_t;

  // Result item.
  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame_out;
    logic                  readonly_out;
    logic [IDX_W-1:0]      slot;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;
    logic [CNT_W-1:0]      change_total;
  } tlbc_out_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic                  lookup_en;
    logic                  write_en;
    logic                  skip_en;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic                  ro;
  } tlbc_cmd_t;

  // Lookup chain: first match found so far and its contents.
  typedef struct packed {
    logic                  found;
    logic [FRAME_BITS-1:0] frame;
    logic                  ro;
    logic [IDX_W-1:0]      slot;
  } tlbc_hit_t;

  // Hand chain: reference bit and index of the cell holding the hand.
  typedef struct packed {
    logic             refb;
    logic [IDX_W-1:0] slot;
  } tlbc_tok_t;

endpackage

// ===== hw/rtl/tlbc_cell.sv =====
// One TLB entry cell: stores an entry, compares it, and passes the clock hand.
`timescale 1ns / 1ps

module tlbc_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [tlbc_pkg::IDX_W-1:0]         cell_idx,
  input  tlbc_pkg::tlbc_cmd_t                cmd,
  input  tlbc_pkg::tlbc_hit_t                hit_in,
  output tlbc_pkg::tlbc_hit_t                hit_out,
  input  tlbc_pkg::tlbc_tok_t                tok_in,
  output tlbc_pkg::tlbc_tok_t                tok_out,
  input  logic                               pass_in,
  output logic                               pass_out,
  output logic                               token_o
);

  logic [tlbc_pkg::PAGE_BITS-1:0]  page_r;
  logic [tlbc_pkg::FRAME_BITS-1:0] frame_r;
  logic                            ro_r;
  logic                            valid_r, valid_nxt;
  logic                            ref_r, ref_nxt;
  logic                            token_r, token_nxt;
  logic                            match;
  logic                            sel;
  logic                            wr_here;

  // Compare against the broadcast page; the first match along the chain wins.
  assign match = valid_r && (page_r == cmd.page);
  assign sel   = match && !hit_in.found;

  always_comb begin
    hit_out.found = hit_in.found | match;
    if (sel) begin
      hit_out.frame = frame_r;
      hit_out.ro    = ro_r;
      hit_out.slot  = cell_idx;
    end else begin
      hit_out.frame = hit_in.frame;
      hit_out.ro    = hit_in.ro;
      hit_out.slot  = hit_in.slot;
    end
  end

  // Report the hand holder's reference bit and index down the chain.
  assign tok_out.refb = tok_in.refb | (token_r & ref_r);
  assign tok_out.slot = tok_in.slot | (token_r ? cell_idx : '0);

  // The hand moves on after a write or a skip at this cell.
  assign wr_here   = token_r && cmd.write_en;
  assign pass_out  = token_r && (cmd.write_en || cmd.skip_en);
  assign token_nxt = pass_in | (token_r & ~pass_out);
  assign token_o   = token_r;

  // Valid and reference bit updates.
  always_comb begin
    valid_nxt = valid_r | wr_here;
    ref_nxt   = ref_r;
    if (wr_here) begin
      ref_nxt = 1'b1;
    end else if (token_r && cmd.skip_en) begin
      ref_nxt = 1'b0;
    end else if (cmd.lookup_en && sel) begin
      ref_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ref_r   <= 1'b0;
      token_r <= (cell_idx == '0);
    end else begin
      valid_r <= valid_nxt;
      ref_r   <= ref_nxt;
      token_r <= token_nxt;
    end
  end

  // Entry contents.
  always_ff @(posedge clk) begin
    if (wr_here) begin
      page_r  <= cmd.page;
      frame_r <= cmd.frame;
      ro_r    <= cmd.ro;
    end
  end

endmodule

// ===== hw/rtl/tlb_clock_replacement.sv =====
// Top level: controller, statistics counters and the chain of entry cells.
// An accepted item is registered and handled in the work state; its result is
// registered when that state finishes. No new item is taken until the block is idle.
// The cell chain compares in the work state. Once the buffer is full an insert skips
// referenced entries under the hand first, at most ENTRIES; a stalled result holds off the next item.
// Synchronous reset (rst_n low) empties the entries, homes the hand, clears counters.
`timescale 1ns / 1ps

module tlb_clock_replacement (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlbc_pkg::tlbc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tlbc_pkg::tlbc_out_t out_data
);

  typedef enum logic {S_IDLE, S_WORK} state_t;

  state_t                            state_r, state_nxt;
  tlbc_pkg::tlbc_in_t                req_r;
  tlbc_pkg::tlbc_out_t               out_r, out_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [tlbc_pkg::FILL_W-1:0]       fill_r, fill_nxt;
  logic [tlbc_pkg::CNT_W-1:0]        hits_r, hits_nxt;
  logic [tlbc_pkg::CNT_W-1:0]        miss_r, miss_nxt;
  logic [tlbc_pkg::CNT_W-1:0]        chg_r, chg_nxt;

  tlbc_pkg::tlbc_cmd_t               cmd;
  tlbc_pkg::tlbc_hit_t               hit_chain [tlbc_pkg::ENTRIES+1];
  tlbc_pkg::tlbc_tok_t               tok_chain [tlbc_pkg::ENTRIES+1];
  logic [tlbc_pkg::ENTRIES-1:0]      pass;
  logic [tlbc_pkg::ENTRIES-1:0]      token_vec;

  logic                              work;
  logic                              is_ins;
  logic                              full;
  logic                              out_free;
  logic                              skip;
  logic                              finish;

  function automatic logic [tlbc_pkg::CNT_W-1:0] sat_inc(
    input logic [tlbc_pkg::CNT_W-1:0] v
  );
    return (&v) ? v : v + 1'b1;
  endfunction

  // Control decode.
  assign work     = (state_r == S_WORK);
  assign is_ins   = (req_r.op == tlbc_pkg::OP_INSERT);
  assign full     = (fill_r == tlbc_pkg::FILL_W'(tlbc_pkg::ENTRIES));
  assign out_free = !out_valid_r || out_ready;
  assign skip     = work && is_ins && full && tok_chain[tlbc_pkg::ENTRIES].refb;
  assign finish   = work && out_free && !skip;
  assign in_ready = (state_r == S_IDLE);

  // Command to the cells.
  always_comb begin
    cmd.lookup_en = finish && !is_ins;
    cmd.write_en  = finish && is_ins;
    cmd.skip_en   = skip;
    cmd.page      = req_r.vpn;
    cmd.frame     = req_r.pfn;
    cmd.ro        = req_r.readonly;
  end

  // Chain of entry cells; the hand wraps from the last cell to the first.
  assign hit_chain[0] = '0;
  assign tok_chain[0] = '0;

  for (genvar i = 0; i < tlbc_pkg::ENTRIES; i++) begin : g_cell
    localparam int PREV = (i == 0) ? tlbc_pkg::ENTRIES - 1 : i - 1;
    tlbc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (tlbc_pkg::IDX_W'(i)),
      .cmd      (cmd),
      .hit_in   (hit_chain[i]),
      .hit_out  (hit_chain[i+1]),
      .tok_in   (tok_chain[i]),
      .tok_out  (tok_chain[i+1]),
      .pass_in  (pass[PREV]),
      .pass_out (pass[i]),
      .token_o  (token_vec[i])
    );
  end

  // Next-state and result logic.
  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    fill_nxt      = fill_r;
    hits_nxt      = hits_r;
    miss_nxt      = miss_r;
    chg_nxt       = chg_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (finish) begin
          state_nxt = S_IDLE;
          out_valid_nxt = 1'b1;
          if (is_ins) begin
            chg_nxt = sat_inc(chg_r);
            if (!full) begin
              fill_nxt = fill_r + 1'b1;
            end
            out_nxt.hit          = 1'b0;
            out_nxt.frame_out    = '0;
            out_nxt.readonly_out = 1'b0;
            out_nxt.slot         = tok_chain[tlbc_pkg::ENTRIES].slot;
          end else begin
            if (hit_chain[tlbc_pkg::ENTRIES].found) begin
              hits_nxt = sat_inc(hits_r);
            end else begin
              miss_nxt = sat_inc(miss_r);
            end
            out_nxt.hit          = hit_chain[tlbc_pkg::ENTRIES].found;
            out_nxt.frame_out    = hit_chain[tlbc_pkg::ENTRIES].frame;
            out_nxt.readonly_out = hit_chain[tlbc_pkg::ENTRIES].ro;
            out_nxt.slot         = hit_chain[tlbc_pkg::ENTRIES].slot;
          end
          out_nxt.hit_total    = hits_nxt;
          out_nxt.miss_total   = miss_nxt;
          out_nxt.change_total = chg_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
      chg_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      hits_r      <= hits_nxt;
      miss_r      <= miss_nxt;
      chg_r       <= chg_nxt;
    end
  end

  // Item and result registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // Exactly one cell holds the clock hand.
  a_hand_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(token_vec))
    else $error("clock hand is not held by exactly one cell");

  // The fill count never passes the number of entries.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= tlbc_pkg::FILL_W'(tlbc_pkg::ENTRIES))
    else $error("fill count out of range");

  // The hand only skips entries once the buffer is full.
  a_skip_full: assert property (@(posedge clk) disable iff (!rst_n)
    skip |-> full)
    else $error("clock skip while buffer not full");

  // During filling the hand sits at the next free slot.
  a_fill_hand: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write_en && !full) |-> (tok_chain[tlbc_pkg::ENTRIES].slot ==
      fill_r[tlbc_pkg::IDX_W-1:0]))
    else $error("fill write not at the hand position");

  // A fill write raises the fill count by one.
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write_en && !full) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("fill count did not advance");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the TLB with second-chance clock replacement.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_ITEMS   = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int POOL_DEPTH   = tlbc_pkg::ENTRIES + 4;

  // One row of stimulus; golden is used only where typed is set.
  typedef struct {
    tlbc_pkg::tlbc_in_t  item;
    bit                  typed;
    tlbc_pkg::tlbc_out_t golden;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  tlbc_pkg::tlbc_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  tlbc_pkg::tlbc_out_t out_data;

  // Shadow copy of the buffer used for prediction.
  bit [tlbc_pkg::PAGE_BITS-1:0]  shadow_page  [tlbc_pkg::ENTRIES];
  bit [tlbc_pkg::FRAME_BITS-1:0] shadow_frame [tlbc_pkg::ENTRIES];
  bit                            shadow_ro    [tlbc_pkg::ENTRIES];
  bit                            shadow_valid [tlbc_pkg::ENTRIES];
  bit                            shadow_refb  [tlbc_pkg::ENTRIES];
  int unsigned                   shadow_hand;
  int unsigned                   shadow_filled;
  bit [tlbc_pkg::CNT_W-1:0]      shadow_hits;
  bit [tlbc_pkg::CNT_W-1:0]      shadow_misses;
  bit [tlbc_pkg::CNT_W-1:0]      shadow_inserts;

  // Run statistics for the closing summary.
  int unsigned lookups_seen;
  int unsigned evictions_seen;
  int unsigned skips_seen;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          calm_tail;

  stim_row_t                      pending_rows[$];
  tlbc_pkg::tlbc_out_t            expected_results[$];
  logic [tlbc_pkg::PAGE_BITS-1:0] recent_pages[$];

  tlb_clock_replacement u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic tlbc_pkg::tlbc_in_t pack_item(
    logic op, logic [tlbc_pkg::PAGE_BITS-1:0] page,
    logic [tlbc_pkg::FRAME_BITS-1:0] frame, logic ro);
    tlbc_pkg::tlbc_in_t item;
    item.op       = op;
    item.vpn      = page;
    item.pfn      = frame;
    item.readonly = ro;
    return item;
  endfunction

  function automatic tlbc_pkg::tlbc_out_t pack_result(
    logic hit, logic [tlbc_pkg::FRAME_BITS-1:0] frame,
    logic ro, logic [tlbc_pkg::IDX_W-1:0] slot,
    logic [tlbc_pkg::CNT_W-1:0] hits, logic [tlbc_pkg::CNT_W-1:0] misses,
    logic [tlbc_pkg::CNT_W-1:0] inserts);
    tlbc_pkg::tlbc_out_t res;
    res.hit          = hit;
    res.frame_out    = frame;
    res.readonly_out = ro;
    res.slot         = slot;
    res.hit_total    = hits;
    res.miss_total   = misses;
    res.change_total = inserts;
    return res;
  endfunction

  function automatic bit [tlbc_pkg::CNT_W-1:0] sat_bump(bit [tlbc_pkg::CNT_W-1:0] value);
    return (value == '1) ? value : value + 1'b1;
  endfunction

  // Apply one item to the shadow buffer and return the result it should give.
  task automatic tlb_predict(input tlbc_pkg::tlbc_in_t item,
                             output tlbc_pkg::tlbc_out_t res);
    int match;
    int i;
    int unsigned victim;
    res = '0;
    if (item.op == tlbc_pkg::OP_LOOKUP) begin
      lookups_seen++;
      match = -1;
      for (i = 0; i < tlbc_pkg::ENTRIES; i++) begin
        if (match < 0 && shadow_valid[i] && shadow_page[i] == item.vpn) match = i;
      end
      if (match >= 0) begin
        res.hit          = 1'b1;
        res.frame_out    = shadow_frame[match];
        res.readonly_out = shadow_ro[match];
        res.slot         = tlbc_pkg::IDX_W'(match);
        shadow_refb[match] = 1'b1;
        shadow_hits = sat_bump(shadow_hits);
      end else begin
        shadow_misses = sat_bump(shadow_misses);
      end
    end else begin
      shadow_inserts = sat_bump(shadow_inserts);
      if (shadow_filled < tlbc_pkg::ENTRIES) begin
        // Free slots are taken in index order while the buffer fills.
        victim = shadow_filled;
        shadow_filled++;
        shadow_refb[victim] = 1'b1;
        shadow_hand = (shadow_hand + 1) % tlbc_pkg::ENTRIES;
      end else begin
        // Second chance: clear and skip referenced entries until one is clear.
        evictions_seen++;
        while (shadow_refb[shadow_hand]) begin
          shadow_refb[shadow_hand] = 1'b0;
          shadow_hand = (shadow_hand + 1) % tlbc_pkg::ENTRIES;
          skips_seen++;
        end
        victim = shadow_hand;
        shadow_refb[victim] = 1'b1;
        shadow_hand = (shadow_hand + 1) % tlbc_pkg::ENTRIES;
      end
      shadow_page[victim]  = item.vpn;
      shadow_frame[victim] = item.pfn;
      shadow_ro[victim]    = item.readonly;
      shadow_valid[victim] = 1'b1;
      res.slot = tlbc_pkg::IDX_W'(victim);
    end
    res.hit_total    = shadow_hits;
    res.miss_total   = shadow_misses;
    res.change_total = shadow_inserts;
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
  endtask

  task automatic compare_result(input tlbc_pkg::tlbc_out_t got,
                                input tlbc_pkg::tlbc_out_t want);
    if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
    if (got.frame_out !== want.frame_out)
      report_mismatch("frame_out", 64'(got.frame_out), 64'(want.frame_out));
    if (got.readonly_out !== want.readonly_out)
      report_mismatch("readonly_out", 64'(got.readonly_out), 64'(want.readonly_out));
    if (got.slot !== want.slot)
      report_mismatch("slot", 64'(got.slot), 64'(want.slot));
    if (got.hit_total !== want.hit_total)
      report_mismatch("hit_total", 64'(got.hit_total), 64'(want.hit_total));
    if (got.miss_total !== want.miss_total)
      report_mismatch("miss_total", 64'(got.miss_total), 64'(want.miss_total));
    if (got.change_total !== want.change_total)
      report_mismatch("change_total", 64'(got.change_total), 64'(want.change_total));
  endtask

  // Offer one item, with an optional idle burst before it, and wait for acceptance.
  task automatic send_item(input stim_row_t row);
    pending_rows.push_back(row);
    if (!calm_tail && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= row.item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check each delivered item first, then record what an accepted item should give.
  always @(posedge clk) begin
    tlbc_pkg::tlbc_out_t predicted;
    stim_row_t row;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("item with nothing pending", 64'(out_data.slot), 64'd0);
      end else begin
        compare_result(out_data, expected_results.pop_front());
      end
      results_seen++;
    end
    if (rst_n && in_valid && in_ready) begin
      tlb_predict(in_data, predicted);
      row = pending_rows.pop_front();
      expected_results.push_back(row.typed ? row.golden : predicted);
    end
  end

  // Receiver stalls in random bursts, none starting during the closing stretch.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm_tail && stall_left == 0 && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d items pending",
               cycle_count, expected_results.size());
      $display("tlb_clock_replacement test failed");
      $finish;
    end
  end

  // Stimulus: directed table, then random traffic, then drain.
  initial begin
    stim_row_t directed_rows[$];
    stim_row_t row;
    int i;
    int n;
    int pick;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    calm_tail = 1'b0;

    // Empty buffer, extreme pages and frames, and the first fills.
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_LOOKUP, '0, '0, 1'b0), 1'b1,
                              pack_result(1'b0, '0, 1'b0, '0, 0, 1, 0)});
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_LOOKUP, '1, '1, 1'b1), 1'b1,
                              pack_result(1'b0, '0, 1'b0, '0, 0, 2, 0)});
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_INSERT, '1, '1, 1'b1), 1'b1,
                              pack_result(1'b0, '0, 1'b0, tlbc_pkg::IDX_W'(0), 0, 2, 1)});
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_LOOKUP, '1, '0, 1'b0), 1'b1,
                              pack_result(1'b1, '1, 1'b1, tlbc_pkg::IDX_W'(0), 1, 2, 1)});
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_INSERT, '0, '0, 1'b0), 1'b1,
                              pack_result(1'b0, '0, 1'b0, tlbc_pkg::IDX_W'(1), 1, 2, 2)});
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_LOOKUP, '0, '1, 1'b1), 1'b1,
                              pack_result(1'b1, '0, 1'b0, tlbc_pkg::IDX_W'(1), 2, 2, 2)});
    // A duplicate page: the lookup must still report the lower slot.
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_INSERT, '0, 16'h1234, 1'b1), 1'b0, '0});
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_LOOKUP, '0, '0, 1'b0), 1'b0, '0});
    // Fill the remaining slots with walking patterns.
    for (i = 3; i < tlbc_pkg::ENTRIES; i++) begin
      directed_rows.push_back('{pack_item(tlbc_pkg::OP_INSERT,
                                          tlbc_pkg::PAGE_BITS'(i * 20'h11111),
                                          tlbc_pkg::FRAME_BITS'(1 << i), i[0]), 1'b0, '0});
    end
    // Full buffer with every reference bit set: a whole turn, then slot 0 goes.
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_INSERT, 20'h12345, 16'h5A5A, 1'b0),
                              1'b1,
                              pack_result(1'b0, '0, 1'b0, tlbc_pkg::IDX_W'(0), 3, 2, 17)});
    // The all-ones page is gone from slot 0 but the last fill also holds it.
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_LOOKUP, '1, '0, 1'b0), 1'b0, '0});
    // A referenced entry under the hand gets its second chance.
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_LOOKUP, '0, '0, 1'b0), 1'b0, '0});
    directed_rows.push_back('{pack_item(tlbc_pkg::OP_INSERT, 20'hABCDE, 16'hC3C3, 1'b1),
                              1'b0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) send_item(directed_rows[k]);

    // Random traffic: lookups of recently inserted pages keep reference bits busy,
    // and a narrow page range makes duplicates and repeated hits common.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm_tail = (n >= RANDOM_ITEMS - CALM_ITEMS);
      row.typed  = 1'b0;
      row.golden = '0;
      row.item   = pack_item(tlbc_pkg::OP_LOOKUP, tlbc_pkg::PAGE_BITS'($urandom),
                             tlbc_pkg::FRAME_BITS'($urandom), 1'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 45 && recent_pages.size() > 0) begin
        row.item.vpn = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
      end else if (pick < 60) begin
        if ($urandom_range(0, 1) == 0)
          row.item.vpn = tlbc_pkg::PAGE_BITS'($urandom_range(0, 63));
      end else begin
        row.item.op = tlbc_pkg::OP_INSERT;
        if ($urandom_range(0, 3) != 0)
          row.item.vpn = tlbc_pkg::PAGE_BITS'($urandom_range(0, 63));
        recent_pages.push_back(row.item.vpn);
        if (recent_pages.size() > POOL_DEPTH) void'(recent_pages.pop_front());
      end
      send_item(row);
    end
    in_valid <= 1'b0;

    // Drain, then allow for a worst-case clock scan before closing.
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (tlbc_pkg::ENTRIES + 8) @(posedge clk);

    $display("Checked %0d items: %0d lookups (%0d hits, %0d misses), %0d inserts.",
             results_seen, lookups_seen, shadow_hits, shadow_misses, shadow_inserts);
    $display("Clock replacement ran %0d evictions with %0d second-chance skips; %0d mismatches.",
             evictions_seen, skips_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tlb_clock_replacement test passed");
    end else begin
      $display("tlb_clock_replacement test failed");
    end
    $finish;
  end

endmodule
